// ===== rtl/core/stored_png_rgb_unpacker_assert.svh =====
// assertion macros for the stored png rgb unpacker
`ifndef STORED_PNG_RGB_UNPACKER_ASSERT_SVH
`define STORED_PNG_RGB_UNPACKER_ASSERT_SVH

`ifndef SYNTH
`define STP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define STP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STP_ASSERT(lbl, prop, msg)
`define STP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/stp_pkg.sv =====
package stp_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        file_start;
    logic [15:0] file_bytes;
  } stp_in_t;

  typedef struct packed {
    logic        is_error;
    logic [31:0] pixel_word;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic        image_done;
    logic [3:0]  status_code;
  } stp_out_t;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HEIGHT = 1'd1;
  localparam logic [7:0] MAX_WIDTH_RESET  = 8'd144;
  localparam logic [7:0] MAX_HEIGHT_RESET = 8'd80;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] MIN_FILE_BYTES = 16'd45;
  localparam logic [7:0]  OPAQUE_ALPHA   = 8'hFF;
  localparam logic [31:0] IDAT_TAG       = 32'h49444154;
  localparam logic [7:0]  ZLIB_CMF       = 8'h78;
  localparam logic [7:0]  ZLIB_FLG       = 8'h01;

  localparam logic [7:0] SIG_BYTES [16] = '{
    8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
    8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52
  };
  localparam logic [7:0] FMT_BYTES [5] = '{8'h08, 8'h02, 8'h00, 8'h00, 8'h00};

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SIGNATURE = 4'd1;
  localparam logic [3:0] ST_FORMAT    = 4'd2;
  localparam logic [3:0] ST_SIZE      = 4'd3;
  localparam logic [3:0] ST_NO_IDAT   = 4'd4;
  localparam logic [3:0] ST_TRUNCATED = 4'd5;
  localparam logic [3:0] ST_ZLIB      = 4'd6;
  localparam logic [3:0] ST_BLOCK_HDR = 4'd7;
  localparam logic [3:0] ST_LENGTH    = 4'd8;
  localparam logic [3:0] ST_NLENGTH   = 4'd9;
  localparam logic [3:0] ST_FILTER    = 4'd10;

endpackage

// ===== rtl/core/stored_png_rgb_unpacker.sv =====
// Stored-block PNG RGB unpacker.
// Input side is a queue write port: one file byte per transfer (push while
// full is low) with file_start on the first byte of a file and the file
// length sampled with it. Result side is a queue read port: while empty is
// low the oldest result sits on result, and pop takes it.
// Each byte gives zero or one result: a pixel (RGB packed with opaque alpha
// and its coordinates) or a single error code that ends the file.
// A result is visible in the cycle after the byte transfer that caused
// it. Throughput: one byte per cycle while full is low, as the parser
// handles each byte as it is taken; bytes keep flowing while results wait.
// A four-entry result queue sits between parser and output; with the
// receiver stalled, full rises once four results wait and the input holds.
// Limit registers are written through wr_en/wr_index/wr_data, index 0 is
// the maximum width and index 1 the maximum height, taken at the edge.
// Reset empties the queue, puts the parser in idle (bytes before a file
// start are dropped) and sets the limits to 144 by 80.
module stored_png_rgb_unpacker import stp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  stp_in_t                item,
  input  logic                   pop,
  output logic                   empty,
  output stp_out_t               result,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  `include "stored_png_rgb_unpacker_assert.svh"

  logic                  res_valid;
  stp_out_t              res;
  logic [FIFO_CNT_W-1:0] fifo_count;

  stp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (push && !full),
    .item      (item),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res       (res)
  );

  stp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_valid),
    .wdata (res),
    .full  (full),
    .rd    (pop),
    .rdata (result),
    .empty (empty),
    .count (fifo_count)
  );

  `STP_ASSERT_ALWAYS(a_reset_empty, rst |=> empty, "queue not empty after reset")
  `STP_ASSERT(a_full_empty, !(full && empty), "queue full and empty at once")
  `STP_ASSERT(a_result_needs_byte, res_valid |-> (push && !full), "result without transfer")
  `STP_ASSERT(a_count_up, (res_valid && !(pop && !empty)) |=> (fifo_count == $past(fifo_count) + 1'b1), "result lost")

endmodule

// ===== rtl/core/stp_parser.sv =====
module stp_parser import stp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  stp_in_t                item,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output logic                   res_valid,
  output stp_out_t               res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_IHDR   = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_HEAD   = 3'd3;
  localparam logic [2:0] PH_ZLIB   = 3'd4;
  localparam logic [2:0] PH_ROWHDR = 3'd5;
  localparam logic [2:0] PH_PIXELS = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  logic [7:0]  max_w, max_h;
  logic [2:0]  phase, phase_next;
  logic [15:0] off, off_next;
  logic [15:0] flen, flen_next;
  logic [7:0]  img_w, img_w_next, img_h, img_h_next;
  logic [15:0] cstart, cstart_next;
  logic [63:0] hdr, hdr_next;
  logic [7:0]  row, row_next, col, col_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  bip, bip_next;
  logic [2:0]  step, step_next;

  always_comb begin
    logic        restart;
    logic [2:0]  c_phase, c_step, rel;
    logic [15:0] c_off, c_cstart, c_acc;
    logic [7:0]  c_row, c_col, c_w, c_h, b, col1, row1;
    logic [63:0] c_hdr, sh;
    logic [1:0]  c_bip;
    logic        err;
    logic [3:0]  code;
    logic [32:0] nxt;
    logic [15:0] lenv;
    logic [9:0]  want_len;
    logic [8:0]  row_inc;

    restart  = take && item.file_start;
    b        = item.data_byte;
    c_phase  = restart ? PH_IHDR : phase;
    c_off    = restart ? '0 : off;
    c_cstart = restart ? '0 : cstart;
    c_hdr    = restart ? '0 : hdr;
    c_row    = restart ? '0 : row;
    c_col    = restart ? '0 : col;
    c_acc    = restart ? '0 : acc;
    c_bip    = restart ? '0 : bip;
    c_step   = restart ? '0 : step;
    c_w      = restart ? '0 : img_w;
    c_h      = restart ? '0 : img_h;

    phase_next  = c_phase;
    off_next    = c_off;
    flen_next   = restart ? item.file_bytes : flen;
    img_w_next  = c_w;
    img_h_next  = c_h;
    cstart_next = c_cstart;
    hdr_next    = c_hdr;
    row_next    = c_row;
    col_next    = c_col;
    acc_next    = c_acc;
    bip_next    = c_bip;
    step_next   = c_step;

    err       = 1'b0;
    code      = ST_OK;
    res_valid = 1'b0;
    res       = '0;
    sh        = {c_hdr[55:0], b};
    rel       = '0;
    nxt       = '0;
    lenv      = {b, c_hdr[7:0]};
    want_len  = 10'd1 + 10'(c_w) * 10'd3;
    row_inc   = {1'b0, c_row} + 9'd1;
    col1      = c_col + 8'd1;
    row1      = c_row + 8'd1;

    if (restart && item.file_bytes < MIN_FILE_BYTES) begin
      err  = 1'b1;
      code = ST_SIGNATURE;
    end else if (take && c_phase != PH_IDLE && c_phase != PH_DONE) begin
      off_next = c_off + 16'd1;
      case (c_phase)
        PH_IHDR: begin
          if (c_off < 16'd16) begin
            if (b != SIG_BYTES[c_off[3:0]]) begin
              err  = 1'b1;
              code = ST_SIGNATURE;
            end
          end else if (c_off < 16'd24) begin
            hdr_next = sh;
          end else if (c_off < 16'd29) begin
            if (b != FMT_BYTES[3'(c_off - 16'd24)]) begin
              err  = 1'b1;
              code = ST_FORMAT;
            end else if (c_off == 16'd28) begin
              if (c_hdr[63:32] == '0 || c_hdr[63:32] > {24'd0, max_w} ||
                  c_hdr[31:0] == '0 || c_hdr[31:0] > {24'd0, max_h}) begin
                err  = 1'b1;
                code = ST_SIZE;
              end else begin
                img_w_next = c_hdr[39:32];
                img_h_next = c_hdr[7:0];
              end
            end
          end else if (c_off == 16'd32) begin
            cstart_next = 16'd33;
            phase_next  = PH_SKIP;
          end
        end
        PH_SKIP, PH_HEAD: begin
          if (c_phase == PH_HEAD || c_off == c_cstart) begin
            rel        = (c_phase == PH_SKIP) ? 3'd0 : c_step;
            hdr_next   = sh;
            phase_next = PH_HEAD;
            step_next  = rel + 3'd1;
            if (rel == 3'd7) begin
              nxt = {17'd0, c_cstart} + 33'd12 + {1'b0, sh[63:32]};
              if (sh[31:0] != IDAT_TAG) begin
                if (nxt + 33'd12 > {17'd0, flen}) begin
                  err  = 1'b1;
                  code = ST_NO_IDAT;
                end else begin
                  cstart_next = nxt[15:0];
                  phase_next  = PH_SKIP;
                end
              end else if (nxt > {17'd0, flen}) begin
                err  = 1'b1;
                code = ST_TRUNCATED;
              end else begin
                phase_next = PH_ZLIB;
                step_next  = '0;
              end
            end
          end
        end
        PH_ZLIB: begin
          if (c_step == 3'd0) begin
            step_next = 3'd1;
            if (b != ZLIB_CMF) begin
              err  = 1'b1;
              code = ST_ZLIB;
            end
          end else if (b != ZLIB_FLG) begin
            err  = 1'b1;
            code = ST_ZLIB;
          end else begin
            row_next   = '0;
            step_next  = '0;
            phase_next = PH_ROWHDR;
          end
        end
        PH_ROWHDR: begin
          step_next = c_step + 3'd1;
          case (c_step)
            3'd0: begin
              if (b != {7'd0, row_inc == {1'b0, c_h}}) begin
                err  = 1'b1;
                code = ST_BLOCK_HDR;
              end
            end
            3'd1: hdr_next = {56'd0, b};
            3'd2: begin
              hdr_next = {48'd0, lenv};
              if (lenv != {6'd0, want_len}) begin
                err  = 1'b1;
                code = ST_LENGTH;
              end
            end
            3'd3: begin
              if (b != ~c_hdr[7:0]) begin
                err  = 1'b1;
                code = ST_NLENGTH;
              end
            end
            3'd4: begin
              if (b != ~c_hdr[15:8]) begin
                err  = 1'b1;
                code = ST_NLENGTH;
              end
            end
            default: begin
              if (b != 8'd0) begin
                err  = 1'b1;
                code = ST_FILTER;
              end else begin
                col_next   = '0;
                bip_next   = '0;
                acc_next   = '0;
                phase_next = PH_PIXELS;
              end
            end
          endcase
        end
        PH_PIXELS: begin
          if (c_bip == 2'd2) begin
            res_valid      = 1'b1;
            res.pixel_word = {OPAQUE_ALPHA, b, c_acc};
            res.pixel_x    = c_col;
            res.pixel_y    = c_row;
            acc_next       = '0;
            bip_next       = '0;
            col_next       = col1;
            if (col1 >= c_w) begin
              row_next = row1;
              if (row1 >= c_h) begin
                res.image_done = 1'b1;
                phase_next     = PH_DONE;
              end else begin
                step_next  = '0;
                phase_next = PH_ROWHDR;
              end
            end
          end else begin
            if (c_bip == 2'd0) begin
              acc_next[7:0] = b;
            end else begin
              acc_next[15:8] = b;
            end
            bip_next = c_bip + 2'd1;
          end
        end
        default: ;
      endcase
    end

    if (err) begin
      phase_next      = PH_DONE;
      res_valid       = 1'b1;
      res             = '0;
      res.is_error    = 1'b1;
      res.status_code = code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_w  <= MAX_WIDTH_RESET;
      max_h  <= MAX_HEIGHT_RESET;
      phase  <= PH_IDLE;
      off    <= '0;
      flen   <= '0;
      img_w  <= '0;
      img_h  <= '0;
      cstart <= '0;
      row    <= '0;
      col    <= '0;
      bip    <= '0;
      step   <= '0;
    end else begin
      if (wr_en && wr_index == CFG_MAX_WIDTH) begin
        max_w <= wr_data;
      end
      if (wr_en && wr_index == CFG_MAX_HEIGHT) begin
        max_h <= wr_data;
      end
      phase  <= phase_next;
      off    <= off_next;
      flen   <= flen_next;
      img_w  <= img_w_next;
      img_h  <= img_h_next;
      cstart <= cstart_next;
      row    <= row_next;
      col    <= col_next;
      bip    <= bip_next;
      step   <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr <= hdr_next;
    acc <= acc_next;
  end

endmodule

// ===== rtl/core/stp_fifo.sv =====
module stp_fifo import stp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  stp_out_t              wdata,
  output logic                  full,
  input  logic                  rd,
  output stp_out_t              rdata,
  output logic                  empty,
  output logic [FIFO_CNT_W-1:0] count
);

  stp_out_t              mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr, rptr;
  logic                  do_wr, do_rd;

  assign full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
